>>> rtl/rft_pkg.sv
// Shared types and constants for the radius fade transition table.
package rft_pkg;

    localparam int ENTRY_COUNT_DEF = 256;
    localparam int INDEX_W         = 8;
    localparam int COLOR_W         = 24;
    localparam int WORD_W          = 32;
    localparam int RSQ_W           = 63;
    localparam int TICK_W          = 16;
    localparam int PROD_W          = 64;
    localparam int ENTRY_W         = COLOR_W + 3 * WORD_W + RSQ_W;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_FADE  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [WORD_W-1:0]  target;
        logic [WORD_W-1:0]  elapsed;
        logic [WORD_W-1:0]  duration;
        logic [RSQ_W-1:0]   rsq;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_RDWAIT,
        ST_MUL1,
        ST_DIVGO,
        ST_DIV,
        ST_SQ,
        ST_UPDATE,
        ST_NEXT,
        ST_OUT
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load_op;
        logic inc_addr;
        logic mem_clr_wr;
        logic mul1;
        logic div_start;
        logic square;
        logic update;
        logic emit;
    } ctrl_t;

    // Datapath -> controller status
    typedef struct packed {
        logic is_tick;
        logic idx_ok;
        logic addr_last;
        logic needs_div;
        logic div_done;
    } stat_t;

endpackage

>>> rtl/rft_ram.sv
// Generic single-port RAM with registered read.
module rft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rft_div.sv
// Iterative signed 64/32 divider, truncating toward zero, one quotient bit a cycle.
module rft_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import rft_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] shifted;
    logic [63:0] quo_fix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[62:0], dvd_reg[63]};
        trial     = {1'b0, shifted} - {33'd0, dvs_reg};
        if (start)
        begin
            // work on magnitudes, fix the sign at the end
            dvd_next  = dividend[63] ? (64'd0 - dividend) : dividend;
            dvs_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[63] ^ divisor[31];
            rem_next  = 64'd0;
            quo_next  = 64'd0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[62:0], 1'b0};
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quo_fix  = neg_reg ? (64'd0 - quo_reg) : quo_reg;
    assign quotient = quo_fix[31:0];
    assign done     = done_reg;

endmodule

>>> rtl/rft_ctrl.sv
// Sequencing state machine for the radius fade transition table.
module rft_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rft_pkg::stat_t stat,
    output rft_pkg::ctrl_t ctrl,
    output logic           busy
);
    import rft_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.mem_clr_wr = 1'b1;
                ctrl.inc_addr   = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load_op = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_RD:
            begin
                if (!stat.is_tick && !stat.idx_ok)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_RDWAIT;
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                ctrl.mul1  = 1'b1;
                state_next = stat.needs_div ? ST_DIVGO : ST_UPDATE;
            end
            // product is registered now; hand it to the divider
            ST_DIVGO:
            begin
                ctrl.div_start = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                ctrl.square = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
                state_next  = stat.is_tick ? ST_NEXT : ST_OUT;
            end
            ST_NEXT:
            begin
                ctrl.inc_addr = 1'b1;
                state_next    = stat.addr_last ? ST_OUT : ST_RD;
            end
            ST_OUT:
            begin
                ctrl.emit  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rft_dp.sv
// Datapath: entry store, multiplier, divider hookup and update rules.
module rft_dp #(
    parameter int ENTRY_COUNT = rft_pkg::ENTRY_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rft_pkg::ctrl_t                ctrl,
    output rft_pkg::stat_t                stat,
    input  logic [1:0]                    op,
    input  logic [rft_pkg::INDEX_W-1:0]   entry_index,
    input  logic [rft_pkg::TICK_W-1:0]    tick_count,
    input  logic [rft_pkg::WORD_W-1:0]    duration_ticks,
    input  logic [rft_pkg::COLOR_W-1:0]   color_in,
    input  logic [rft_pkg::WORD_W-1:0]    target_radius_in,
    input  logic [rft_pkg::WORD_W-1:0]    elapsed_in,
    output logic                          done,
    output logic [rft_pkg::COLOR_W-1:0]   color_out,
    output logic [rft_pkg::WORD_W-1:0]    target_radius_out,
    output logic [rft_pkg::WORD_W-1:0]    elapsed_out,
    output logic [rft_pkg::WORD_W-1:0]    duration_out,
    output logic [rft_pkg::RSQ_W-1:0]     radius_squared_out
);
    import rft_pkg::*;

    localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CW = AW + 1;

    op_t                 op_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic [WORD_W-1:0]   dur_in_reg;
    logic [COLOR_W-1:0]  color_in_reg;
    logic [WORD_W-1:0]   tgt_in_reg;
    logic [WORD_W-1:0]   ela_in_reg;
    logic [CW-1:0]       addr_reg;
    logic [WORD_W-1:0]   neg_len;
    logic [PROD_W-1:0]   prod_reg;
    logic [WORD_W-1:0]   r_reg;
    logic [RSQ_W-1:0]    rsq_reg;
    entry_t              res_reg;
    logic                done_reg;
    logic                fade_go;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    entry_t              mem_wdata;
    entry_t              cur;
    entry_t              upd;
    logic [WORD_W-1:0]   mul_a;
    logic [WORD_W-1:0]   mul_b;
    logic [WORD_W-1:0]   div_d;
    logic [WORD_W-1:0]   div_q;
    logic                div_done;
    logic [WORD_W-1:0]   new_ela;
    logic [PROD_W-1:0]   sq_full;

    assign neg_len = WORD_W'(0) - dur_in_reg;
    assign fade_go = neg_len[WORD_W-1] && !cur.duration[WORD_W-1];

    always_ff @(posedge clk)
    begin
        if (ctrl.load_op)
        begin
            op_reg       <= op_t'(op);
            idx_reg      <= entry_index;
            tick_reg     <= tick_count;
            dur_in_reg   <= duration_ticks;
            color_in_reg <= color_in;
            tgt_in_reg   <= target_radius_in;
            ela_in_reg   <= elapsed_in;
        end
        if (ctrl.mul1)
        begin
            prod_reg <= PROD_W'($signed(mul_a) * $signed(mul_b));
        end
        if (ctrl.square)
        begin
            rsq_reg <= sq_full[RSQ_W-1:0];
        end
        if (ctrl.update && op_reg != OP_TICK)
        begin
            res_reg <= upd;
        end
        else if (ctrl.load_op)
        begin
            res_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
            if (ctrl.load_op)
            begin
                addr_reg <= '0;
            end
            else if (ctrl.inc_addr)
            begin
                addr_reg <= stat.addr_last ? '0 : addr_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            r_reg <= div_q;
        end
    end

    // square the 32-bit radius, keep the low 63 bits
    assign sq_full = PROD_W'($signed(r_reg) * $signed(r_reg));

    assign mul_a = (op_reg == OP_TICK) ? cur.target : neg_len;
    assign mul_b = cur.elapsed;
    assign div_d = cur.duration;

    rft_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (prod_reg),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mem_addr = (op_reg == OP_TICK || ctrl.mem_clr_wr) ? addr_reg[AW-1:0]
                                                            : AW'(idx_reg);
    assign mem_we    = ctrl.mem_clr_wr || ctrl.update;
    assign mem_wdata = ctrl.mem_clr_wr ? entry_t'('0) : upd;

    rft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (2 ** AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (cur)
    );

    always_comb
    begin
        upd     = cur;
        new_ela = cur.elapsed + WORD_W'(tick_reg);
        case (op_reg)
            OP_TICK:
            begin
                if (stat.needs_div)
                begin
                    upd.elapsed = new_ela;
                    upd.rsq     = rsq_reg;
                    if (cur.duration[WORD_W-1])
                    begin
                        if (!new_ela[WORD_W-1])
                        begin
                            upd = '0;
                        end
                    end
                    else if ($signed(cur.duration) < $signed(new_ela))
                    begin
                        upd.elapsed  = '0;
                        upd.duration = '0;
                    end
                end
            end
            OP_FADE:
            begin
                if (fade_go && cur.duration == '0)
                begin
                    upd.duration = neg_len;
                    upd.elapsed  = neg_len;
                end
                else if (fade_go)
                begin
                    upd.duration = neg_len;
                    upd.elapsed  = r_reg;
                    if (r_reg == '0)
                    begin
                        upd.color  = '0;
                        upd.target = '0;
                        upd.rsq    = '0;
                    end
                end
                else
                begin
                    upd.color  = '0;
                    upd.target = '0;
                    upd.rsq    = '0;
                end
            end
            OP_WRITE:
            begin
                upd.duration = dur_in_reg;
                upd.color    = color_in_reg;
                upd.target   = tgt_in_reg;
                upd.elapsed  = ela_in_reg;
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    always_comb
    begin
        stat.is_tick   = (op_reg == OP_TICK);
        stat.idx_ok    = (32'(idx_reg) < ENTRY_COUNT);
        stat.addr_last = (addr_reg == CW'(ENTRY_COUNT - 1));
        stat.div_done  = div_done;
        case (op_reg)
            OP_TICK: stat.needs_div = (cur.color != '0) && (cur.duration != '0);
            OP_FADE: stat.needs_div = fade_go && (cur.duration != '0);
            default: stat.needs_div = 1'b0;
        endcase
    end

    assign done               = done_reg;
    assign color_out          = res_reg.color;
    assign target_radius_out  = res_reg.target;
    assign elapsed_out        = res_reg.elapsed;
    assign duration_out       = res_reg.duration;
    assign radius_squared_out = res_reg.rsq;

endmodule

>>> rtl/radius_fade_transition_table.sv
// Radius fade transition table: 256-entry fade store with tick, fade-out, write and read.
// Read, write and plain fade-out bypass the divider; an out-of-range index goes
//   straight to done; a scaled fade-out waits on the serial divider; a tick walks
//   every entry and divides only for active ones.
// Throughput: one transaction at a time; busy stays high until done pulses.
// Reset: asynchronous; afterwards a clearing pass over all ENTRY_COUNT entries zeroes
//   the store while busy is high. done pulses one cycle and cannot be held off.
module radius_fade_transition_table #(
    parameter int ENTRY_COUNT = rft_pkg::ENTRY_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic [1:0]                    op,
    input  logic [rft_pkg::INDEX_W-1:0]   entry_index,
    input  logic [rft_pkg::TICK_W-1:0]    tick_count,
    input  logic [rft_pkg::WORD_W-1:0]    duration_ticks,
    input  logic [rft_pkg::COLOR_W-1:0]   color_in,
    input  logic [rft_pkg::WORD_W-1:0]    target_radius_in,
    input  logic [rft_pkg::WORD_W-1:0]    elapsed_in,
    output logic [rft_pkg::COLOR_W-1:0]   color_out,
    output logic [rft_pkg::WORD_W-1:0]    target_radius_out,
    output logic [rft_pkg::WORD_W-1:0]    elapsed_out,
    output logic [rft_pkg::WORD_W-1:0]    duration_out,
    output logic [rft_pkg::RSQ_W-1:0]     radius_squared_out
);
    import rft_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    rft_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    rft_dp #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .stat               (stat),
        .op                 (op),
        .entry_index        (entry_index),
        .tick_count         (tick_count),
        .duration_ticks     (duration_ticks),
        .color_in           (color_in),
        .target_radius_in   (target_radius_in),
        .elapsed_in         (elapsed_in),
        .done               (done),
        .color_out          (color_out),
        .target_radius_out  (target_radius_out),
        .elapsed_out        (elapsed_out),
        .duration_out       (duration_out),
        .radius_squared_out (radius_squared_out)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a transaction in flight");

    a_no_accept_during_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high when result shown");

    a_emit_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

endmodule
